// ===== hdl/wafc_pkg.sv =====
`default_nettype none
package wafc_pkg;
  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_CMD = 2'd1;
  localparam logic [1:0] OP_SLIDER = 2'd2;
  localparam logic [1:0] OP_STOP = 2'd3;

  localparam logic [1:0] MODE_STANDBY = 2'd0;
  localparam logic [1:0] MODE_LAMP = 2'd1;
  localparam logic [1:0] MODE_ALARM = 2'd2;

  localparam logic [4:0] ID_ENABLE = 5'd1;
  localparam logic [4:0] ID_DURATION = 5'd2;
  localparam logic [4:0] ID_HOUR = 5'd3;
  localparam logic [4:0] ID_MINUTE = 5'd4;
  localparam logic [4:0] ID_RTC_HOUR = 5'd5;
  localparam logic [4:0] ID_RTC_MINUTE = 5'd6;
  localparam logic [4:0] ID_RTC_DAY = 5'd7;

  localparam logic [1:0] RTC_NONE = 2'd0;
  localparam logic [1:0] RTC_HOUR = 2'd1;
  localparam logic [1:0] RTC_MINUTE = 2'd2;
  localparam logic [1:0] RTC_DAY = 2'd3;

  localparam logic [5:0] DUR_MAX = 6'd60;
  localparam logic [44:0] INC_NUM = 45'h1000_0000_0000;
  localparam logic [25:0] DIV_UNIT = 26'd60000000;
  localparam logic [15:0] DUTY_MAX = 16'hFFFF;

  typedef struct packed {
    logic start;
    logic div_busy;
  } div_stat_t;

  typedef struct packed {
    logic load;
    logic step;
    logic tick_update;
  } dp_cmd_t;

  function automatic logic [16:0] oct_tab(input logic [3:0] k);
    case (k)
      4'd0: oct_tab = 17'd32768;
      4'd1: oct_tab = 17'd35734;
      4'd2: oct_tab = 17'd38968;
      4'd3: oct_tab = 17'd42495;
      4'd4: oct_tab = 17'd46341;
      4'd5: oct_tab = 17'd50535;
      4'd6: oct_tab = 17'd55109;
      4'd7: oct_tab = 17'd60097;
      default: oct_tab = 17'd65536;
    endcase
  endfunction

  // 2^(ip + frac/2^25) - 1, saturated
  function automatic logic [15:0] pow2m1(input logic [4:0] ip, input logic [24:0] frac);
    logic [2:0] k;
    logic [21:0] rem;
    logic [16:0] lo;
    logic [16:0] hi;
    logic [39:0] prod;
    logic [17:0] mant;
    logic [33:0] sh;
    logic [18:0] val;
    k = frac[24:22];
    rem = frac[21:0];
    lo = oct_tab({1'b0, k});
    hi = oct_tab({1'b0, k} + 4'd1);
    prod = 40'(hi - lo) * 40'(rem);
    mant = 18'(lo) + 18'(prod[39:22]);
    sh = 34'(mant) << ip[3:0];
    val = 19'(sh >> 15) - 19'd1;
    if (ip[4] || (sh >> 15) > 34'd65536) pow2m1 = DUTY_MAX;
    else pow2m1 = val[15:0];
  endfunction
endpackage
`default_nettype wire

// ===== hdl/wakeup_alarm_fade_controller_unit.sv =====
// Each transaction passes the DIV, FIN and OUT states; a tick that starts an alarm
// also waits in DIV for the 45-step restoring divider that computes the fade increment.
// Throughput: one transaction at a time; next accepted after the result is taken.
// Reset (rst, synchronous): alarm table cleared, duration 1 minute, standby,
// off_threshold 2.
`default_nettype none
module wakeup_alarm_fade_controller_unit #(
  parameter int DAYS = 7
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic [1:0] operation,
  input  wire logic [7:0] cmd_byte,
  input  wire logic [9:0] adc_value,
  input  wire logic [4:0] hour,
  input  wire logic [5:0] minute,
  input  wire logic [5:0] second,
  input  wire logic [2:0] weekday,
  input  wire logic alarm_switch,
  output logic out_valid,
  input  wire logic out_stall,
  output logic lamp_on,
  output logic [15:0] duty,
  output logic [1:0] mode,
  output logic [1:0] rtc_write_kind,
  output logic [7:0] rtc_write_value,
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic [9:0] cfg_data
);
  import wafc_pkg::*;
  logic [9:0] off_threshold;
  dp_cmd_t cmd;
  div_stat_t stat;
  logic in_acc;

  assign cfg_ready = 1'b1;
  assign in_acc = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) off_threshold <= 10'd2;
    else if (cfg_valid && cfg_ready) off_threshold <= cfg_data;
  end

  wafc_ctrl u_ctrl (
    .clk, .rst, .in_acc, .out_acc(out_valid && !out_stall), .stat, .cmd,
    .in_stall, .out_valid
  );

  wafc_dp #(.DAYS(DAYS)) u_dp (
    .clk, .rst, .cmd, .stat, .off_threshold, .operation, .cmd_byte, .adc_value,
    .hour, .minute, .second, .weekday, .alarm_switch, .lamp_on, .duty, .mode,
    .rtc_write_kind, .rtc_write_value
  );
endmodule
`default_nettype wire

// ===== hdl/wafc_ctrl.sv =====
`default_nettype none
module wafc_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_acc,
  input  wire logic out_acc,
  input  wire wafc_pkg::div_stat_t stat,
  output wafc_pkg::dp_cmd_t cmd,
  output logic in_stall,
  output logic out_valid
);
  import wafc_pkg::*;
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV = 2'd1;
  localparam logic [1:0] S_FIN = 2'd2;
  localparam logic [1:0] S_OUT = 2'd3;
  logic [1:0] state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: if (in_acc) state <= S_DIV;
        S_DIV: if (!stat.start || !stat.div_busy) state <= S_FIN;
        S_FIN: state <= S_OUT;
        S_OUT: if (out_acc) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    in_stall = (state != S_IDLE);
    out_valid = (state == S_OUT);
    cmd.load = in_acc;
    cmd.step = (state == S_DIV) && stat.start && stat.div_busy;
    cmd.tick_update = (state == S_FIN);
  end
endmodule
`default_nettype wire

// ===== hdl/wafc_dp.sv =====
`default_nettype none
module wafc_dp #(
  parameter int DAYS = 7
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire wafc_pkg::dp_cmd_t cmd,
  output wafc_pkg::div_stat_t stat,
  input  wire logic [9:0] off_threshold,
  input  wire logic [1:0] operation,
  input  wire logic [7:0] cmd_byte,
  input  wire logic [9:0] adc_value,
  input  wire logic [4:0] hour,
  input  wire logic [5:0] minute,
  input  wire logic [5:0] second,
  input  wire logic [2:0] weekday,
  input  wire logic alarm_switch,
  output logic lamp_on,
  output logic [15:0] duty,
  output logic [1:0] mode,
  output logic [1:0] rtc_write_kind,
  output logic [7:0] rtc_write_value
);
  import wafc_pkg::*;
  logic alarm_enable [DAYS];
  logic [4:0] alarm_hour [DAYS];
  logic [5:0] alarm_minute [DAYS];
  logic [5:0] fade_minutes;
  logic byte_phase;
  logic [4:0] pending_id;
  logic [2:0] pending_day;
  logic alarm_running, stop_request;
  logic [32:0] fade_accumulator;
  logic [23:0] fade_increment;
  logic [15:0] lamp_duty;
  logic [9:0] slider_level;
  logic [1:0] op_r;
  logic [7:0] byte_r;
  logic [9:0] adc_r;
  logic start_r;
  // restoring divider
  logic [44:0] quo;
  logic [31:0] remd;
  logic [31:0] dvs;
  logic [5:0] cnt;

  logic [2:0] wd_ix;
  logic wd_ok;
  logic [4:0] ah, sh;
  logic [5:0] am, sm;
  logic match;
  logic [32:0] rem_sh;

  always_comb begin
    wd_ix = weekday;
    wd_ok = 32'(weekday) < DAYS;
    ah = wd_ok ? alarm_hour[wd_ix] : 5'd0;
    am = wd_ok ? alarm_minute[wd_ix] : 6'd0;
    if (am < fade_minutes) begin
      sh = (ah == 5'd0) ? 5'd23 : ah - 5'd1;
      sm = 6'(6'd60 - (fade_minutes - am));
    end else begin
      sh = ah;
      sm = am - fade_minutes;
    end
    match = wd_ok && !alarm_running && hour == sh && minute == sm && alarm_enable[wd_ix]
      && alarm_switch && second == 6'd0;
    rem_sh = {remd, quo[44]};
    stat.start = start_r;
    stat.div_busy = (cnt != 6'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DAYS; i++) begin
        alarm_enable[i] <= 1'b0;
        alarm_hour[i] <= 5'd0;
        alarm_minute[i] <= 6'd0;
      end
      fade_minutes <= 6'd1;
      byte_phase <= 1'b0;
      pending_id <= 5'd0;
      pending_day <= 3'd0;
      alarm_running <= 1'b0;
      stop_request <= 1'b0;
      fade_accumulator <= 33'd0;
      fade_increment <= 24'd0;
      lamp_duty <= 16'd0;
      slider_level <= 10'd0;
      mode <= MODE_STANDBY;
      start_r <= 1'b0;
      cnt <= 6'd0;
      op_r <= OP_TICK;
      rtc_write_kind <= RTC_NONE;
      rtc_write_value <= 8'd0;
    end else begin
      if (cmd.load) begin
        op_r <= operation;
        byte_r <= cmd_byte;
        adc_r <= adc_value;
        start_r <= (operation == OP_TICK) && match;
        rtc_write_kind <= RTC_NONE;
        rtc_write_value <= 8'd0;
        if (operation == OP_TICK && match) begin
          quo <= INC_NUM;
          remd <= 32'd0;
          dvs <= 32'(26'(DIV_UNIT) * 32'(fade_minutes));
          cnt <= 6'd45;
        end
      end
      if (cmd.step) begin
        if (rem_sh >= {1'b0, dvs}) begin
          remd <= 32'(rem_sh - {1'b0, dvs});
          quo <= {quo[43:0], 1'b1};
        end else begin
          remd <= rem_sh[31:0];
          quo <= {quo[43:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
      end
      if (cmd.tick_update) begin : upd
        logic run;
        logic [32:0] acc;
        logic [15:0] d;
        logic [1:0] m;
        logic [9:0] sl;
        run = alarm_running;
        acc = fade_accumulator;
        d = lamp_duty;
        m = mode;
        sl = slider_level;
        case (op_r)
          OP_TICK: begin
            if (start_r) begin
              run = 1'b1;
              acc = 33'd0;
              d = 16'd0;
              fade_increment <= quo[23:0];
              m = MODE_ALARM;
            end
            if (run) begin
              if (stop_request) begin
                run = 1'b0;
                stop_request <= 1'b0;
                m = MODE_STANDBY;
              end
              if (d != DUTY_MAX)
                acc = acc + 33'(start_r ? quo[23:0] : fade_increment);
              d = pow2m1(5'(acc[32:28]), acc[27:3]);
            end
          end
          OP_CMD: begin
            if (!byte_phase) begin
              pending_id <= byte_r[7:3];
              pending_day <= byte_r[2:0];
              byte_phase <= 1'b1;
            end else begin
              byte_phase <= 1'b0;
              case (pending_id)
                ID_ENABLE: if (32'(pending_day) < DAYS)
                  alarm_enable[pending_day] <= byte_r[0];
                ID_DURATION: fade_minutes <= (byte_r == 8'd0) ? 6'd1 :
                  ((byte_r > 8'(DUR_MAX)) ? DUR_MAX : byte_r[5:0]);
                ID_HOUR: if (32'(pending_day) < DAYS && byte_r <= 8'd23)
                  alarm_hour[pending_day] <= byte_r[4:0];
                ID_MINUTE: if (32'(pending_day) < DAYS && byte_r <= 8'd59)
                  alarm_minute[pending_day] <= byte_r[5:0];
                ID_RTC_HOUR: begin
                  rtc_write_kind <= RTC_HOUR; rtc_write_value <= byte_r;
                end
                ID_RTC_MINUTE: begin
                  rtc_write_kind <= RTC_MINUTE; rtc_write_value <= byte_r;
                end
                ID_RTC_DAY: begin
                  rtc_write_kind <= RTC_DAY; rtc_write_value <= byte_r;
                end
                default: ;
              endcase
            end
          end
          OP_SLIDER: if (!run) begin
            sl = adc_r;
            d = pow2m1({1'b0, adc_r[9:6]}, {adc_r[5:0], 19'd0});
          end
          default: if (run) stop_request <= 1'b1;
        endcase
        if (m == MODE_STANDBY && sl >= off_threshold) m = MODE_LAMP;
        else if (m == MODE_LAMP && sl < off_threshold) m = MODE_STANDBY;
        alarm_running <= run;
        fade_accumulator <= acc;
        lamp_duty <= d;
        mode <= m;
        slider_level <= sl;
        start_r <= 1'b0;
      end
    end
  end

  assign lamp_on = (mode != MODE_STANDBY);
  assign duty = lamp_duty;
endmodule
`default_nettype wire

// ===== hdl/wafc_checker.sv =====
`default_nettype none
module wafc_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic lamp_on,
  input wire logic [1:0] mode,
  input wire logic [1:0] rtc_write_kind,
  input wire logic [7:0] rtc_write_value
);
  import wafc_pkg::*;
  a_lamp: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (lamp_on == (mode != MODE_STANDBY))) else $error("lamp_on mismatch");
  a_rtc: assert property (@(posedge clk) disable iff (rst)
    out_valid && rtc_write_kind == RTC_NONE |-> rtc_write_value == 8'd0)
    else $error("rtc value without kind");
  a_one: assert property (@(posedge clk) disable iff (rst)
    out_valid && in_valid |-> in_stall) else $error("input taken with result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(mode))
    else $error("stalled result changed");
endmodule

bind wakeup_alarm_fade_controller_unit wafc_checker u_chk (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .lamp_on, .mode,
  .rtc_write_kind, .rtc_write_value
);
`default_nettype wire

// ===== bench/tb.sv =====
`default_nettype none
module tb;
  import wafc_pkg::*;

  localparam int NDAYS = 7;
  localparam int CYCLE_LIMIT = 900000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] operation = OP_TICK;
  logic [7:0] cmd_byte = '0;
  logic [9:0] adc_value = '0;
  logic [4:0] hour = '0;
  logic [5:0] minute = '0;
  logic [5:0] second = '0;
  logic [2:0] weekday = '0;
  logic alarm_switch = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic lamp_on;
  logic [15:0] duty;
  logic [1:0] mode;
  logic [1:0] rtc_write_kind;
  logic [7:0] rtc_write_value;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [9:0] cfg_data = '0;

  typedef struct packed {
    logic lamp_on;
    logic [15:0] duty;
    logic [1:0] mode;
    logic [1:0] rtc_kind;
    logic [7:0] rtc_value;
  } lamp_status_t;

  wakeup_alarm_fade_controller_unit #(.DAYS(NDAYS)) dut (.*);

  always #5 clk = ~clk;

  // predictor state
  logic [9:0] threshold;
  logic en_tab [NDAYS];
  logic [4:0] hr_tab [NDAYS];
  logic [5:0] mn_tab [NDAYS];
  logic [5:0] fade_min;
  logic second_byte;
  logic [4:0] held_id;
  logic [2:0] held_day;
  logic running;
  logic stop_pending;
  logic [1:0] lamp_mode;
  logic [32:0] acc;
  logic [23:0] incr;
  logic [15:0] lamp_duty;
  logic [9:0] slider;

  lamp_status_t expected_status[$];
  int errors = 0;
  int cycles = 0;
  bit hold_receiver = 0;

  function automatic logic [15:0] exp2_duty(input logic [32:0] ip, input logic [24:0] frac);
    int unsigned tabv [9] = '{32768, 35734, 38968, 42495, 46341, 50535, 55109, 60097, 65536};
    int unsigned k;
    longint unsigned mant, v;
    k = frac[24:22];
    mant = tabv[k] + (((longint'(tabv[k+1] - tabv[k])) * frac[21:0]) >> 22);
    if (ip >= 16) return 16'hFFFF;
    v = ((mant << ip) >> 15) - 1;
    if (v > 65535) v = 65535;
    return v[15:0];
  endfunction

  task automatic model_reset();
    threshold = 10'd2;
    for (int d = 0; d < NDAYS; d++) begin
      en_tab[d] = 0; hr_tab[d] = 0; mn_tab[d] = 0;
    end
    fade_min = 1; second_byte = 0; held_id = 0; held_day = 0;
    running = 0; stop_pending = 0; lamp_mode = MODE_STANDBY;
    acc = 0; incr = 0; lamp_duty = 0; slider = 0;
  endtask

  task automatic predict_lamp(input logic [1:0] op, input logic [7:0] b, input logic [9:0] a,
                              input logic [4:0] h, input logic [5:0] m, input logic [5:0] s,
                              input logic [2:0] wd, input logic sw);
    lamp_status_t r;
    logic [4:0] sh;
    logic [5:0] sm;
    logic [1:0] kind;
    logic [7:0] val;
    kind = RTC_NONE; val = 0;
    case (op)
      OP_TICK: begin
        if (wd < NDAYS && !running) begin
          if (mn_tab[wd] < fade_min) begin
            sh = (hr_tab[wd] == 0) ? 5'd23 : hr_tab[wd] - 1;
            sm = 6'd60 - (fade_min - mn_tab[wd]);
          end else begin
            sh = hr_tab[wd];
            sm = mn_tab[wd] - fade_min;
          end
          if (h == sh && m == sm && en_tab[wd] && sw && s == 0) begin
            running = 1; acc = 0; lamp_duty = 0;
            incr = 24'((64'd1 << 44) / (64'd60000000 * fade_min));
            lamp_mode = MODE_ALARM;
          end
        end
        if (running) begin
          if (stop_pending) begin
            running = 0; stop_pending = 0; lamp_mode = MODE_STANDBY;
          end
          if (lamp_duty != 16'hFFFF) acc = acc + incr;
          lamp_duty = exp2_duty(acc >> 28, acc[27:3]);
        end
      end
      OP_CMD: begin
        if (!second_byte) begin
          held_id = b[7:3]; held_day = b[2:0]; second_byte = 1;
        end else begin
          second_byte = 0;
          case (held_id)
            ID_ENABLE: if (held_day < NDAYS) en_tab[held_day] = b[0];
            ID_DURATION: fade_min = (b < 1) ? 6'd1 : (b > 60 ? DUR_MAX : b[5:0]);
            ID_HOUR: if (held_day < NDAYS && b <= 23) hr_tab[held_day] = b[4:0];
            ID_MINUTE: if (held_day < NDAYS && b <= 59) mn_tab[held_day] = b[5:0];
            ID_RTC_HOUR: begin kind = RTC_HOUR; val = b; end
            ID_RTC_MINUTE: begin kind = RTC_MINUTE; val = b; end
            ID_RTC_DAY: begin kind = RTC_DAY; val = b; end
            default: ;
          endcase
        end
      end
      OP_SLIDER: begin
        if (!running) begin
          slider = a;
          lamp_duty = exp2_duty(a >> 6, {a[5:0], 19'd0});
        end
      end
      default: if (running) stop_pending = 1;
    endcase
    if (lamp_mode == MODE_STANDBY) begin
      if (slider >= threshold) lamp_mode = MODE_LAMP;
    end else if (lamp_mode == MODE_LAMP) begin
      if (slider < threshold) lamp_mode = MODE_STANDBY;
    end
    r.lamp_on = lamp_mode != MODE_STANDBY;
    r.duty = lamp_duty;
    r.mode = lamp_mode;
    r.rtc_kind = kind;
    r.rtc_value = val;
    expected_status.push_back(r);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver stall
  initial begin
    int w;
    w = 0;
    forever begin
      @(posedge clk);
      if (hold_receiver) begin
        out_stall <= 1'b1;
        w = 0;
      end else if (w > 1) begin
        w--;
      end else if (out_valid && !out_stall) begin
        w = $urandom_range(0, 15);
        if ($urandom_range(0, 3) == 0) w = 0;
        out_stall <= (w != 0);
      end else begin
        out_stall <= 1'b0;
        w = 0;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    lamp_status_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = '{lamp_on, duty, mode, rtc_write_kind, rtc_write_value};
      if (expected_status.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected transaction: %p", got);
      end else begin
        want = expected_status.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  task automatic send(input logic [1:0] op, input logic [7:0] b = 0, input logic [9:0] a = 0,
                      input logic [4:0] h = 0, input logic [5:0] m = 0,
                      input logic [5:0] s = 0, input logic [2:0] wd = 0,
                      input logic sw = 1, input bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 15);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap + 1) @(posedge clk);
    in_valid <= 1; operation <= op; cmd_byte <= b; adc_value <= a;
    hour <= h; minute <= m; second <= s; weekday <= wd; alarm_switch <= sw;
    do @(posedge clk); while (in_stall);
    predict_lamp(op, b, a, h, m, s, wd, sw);
    in_valid <= 0;
  endtask

  task automatic command(input logic [4:0] id, input logic [2:0] d, input logic [7:0] v);
    send(OP_CMD, {id, d});
    send(OP_CMD, v);
  endtask

  task automatic drain();
    while (expected_status.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [9:0] v);
    drain();
    cfg_valid <= 1; cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    threshold = v;
  endtask

  task automatic arm_alarm(input logic [2:0] d, input logic [4:0] h, input logic [5:0] m,
                           input logic [7:0] dur);
    command(ID_HOUR, d, h);
    command(ID_MINUTE, d, m);
    command(ID_ENABLE, d, 8'h01);
    command(ID_DURATION, 0, dur);
  endtask

  task automatic test_directed();
    send(OP_SLIDER, 0, 10'd0);
    send(OP_SLIDER, 0, 10'd1023);
    send(OP_SLIDER, 0, 10'd1);
    send(OP_STOP);
    command(ID_RTC_HOUR, 0, 8'hFF);
    command(ID_RTC_MINUTE, 0, 8'h00);
    command(ID_RTC_DAY, 3'd7, 8'hA5);
    command(5'd0, 0, 8'h12);
    command(5'd31, 7, 8'h12);
    command(ID_HOUR, 3'd7, 8'd5);
    command(ID_HOUR, 0, 8'd24);
    arm_alarm(0, 0, 0, 8'd0);
    send(OP_TICK, 0, 0, 23, 59, 0, 0, 1);
    send(OP_SLIDER, 0, 10'd500);
    send(OP_TICK, 0, 0, 0, 0, 0, 7, 1);
    send(OP_STOP);
    send(OP_TICK);
    command(ID_DURATION, 0, 8'd200);
  endtask

  task automatic test_alarm_fades(input int n);
    logic [2:0] d;
    logic [4:0] h;
    logic [5:0] m, dur;
    for (int i = 0; i < n; i++) begin
      d = $urandom_range(0, 6); h = $urandom_range(0, 23); m = $urandom_range(0, 59);
      dur = (i % 4 == 0) ? 1 : $urandom_range(1, 60);
      arm_alarm(d, h, m, dur);
      if (m < dur) send(OP_TICK, 0, 0, h == 0 ? 23 : h - 1, 60 - (dur - m), 0, d, 1);
      else send(OP_TICK, 0, 0, h, m - dur, 0, d, 1);
      for (int t = 0; t < $urandom_range(3, 30); t++) begin
        case ($urandom_range(0, 9))
          0: send(OP_SLIDER, 0, $urandom_range(0, 1023));
          1: send(OP_STOP);
          default: send(OP_TICK, 0, 0, $urandom_range(0, 31), $urandom_range(0, 63),
                        $urandom_range(0, 63), $urandom_range(0, 7), $urandom_range(0, 1));
        endcase
      end
      send(OP_STOP);
      send(OP_TICK);
    end
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++)
      send($urandom_range(0, 3), $urandom_range(0, 255), $urandom_range(0, 1023),
           $urandom_range(0, 31), $urandom_range(0, 63), $urandom_range(0, 63),
           $urandom_range(0, 7), $urandom_range(0, 1));
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_receiver = 1;
        repeat (200) @(posedge clk);
        hold_receiver = 0;
      end
      for (int i = 0; i < 8; i++) send(OP_SLIDER, 0, $urandom_range(0, 1023), 0, 0, 0, 0, 1, 1);
    join
    drain();
  endtask

  initial begin
    model_reset();
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    write_threshold(10'd0);
    test_random(200);
    write_threshold(10'd1023);
    test_alarm_fades(20);
    test_backpressure();
    write_threshold($urandom_range(1, 1022));
    test_alarm_fades(20);
    write_threshold(10'd2);
    test_random(300);
    drain();
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
`default_nettype wire
